// ===== design/lbct_pkg.sv =====
// Shared constants, operation codes and the cell control word for the
// block cache tag store. No dependencies.
package lbct_pkg;

  localparam int MaxEntriesDefault  = 16;
  localparam int AddressBitsDefault = 48;

  localparam int BsW   = 17;  // block size register width
  localparam int CapW  = 5;   // capacity register width
  localparam int LenW  = 17;  // write length width
  localparam int OffW  = 16;  // inner offset width
  localparam int OSlotW = 4;  // slot width on the result word

  localparam logic [BsW-1:0]  BsReset  = 17'd4096;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_ALLOC  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic CFG_BLOCK_SIZE = 1'b0;
  localparam logic CFG_CAPACITY   = 1'b1;

  // Per-cell command: take the neighbour's entry, or take the shared new entry.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== design/lbct_cell.sv =====
// One entry of the recency row: block base, buffer slot and the hit compare.
// Depends on lbct_pkg.
module lbct_cell #(
  parameter int AW = lbct_pkg::AddressBitsDefault,
  parameter int SW = 4
) (
  input  logic                      clk,
  input  lbct_pkg::cell_ctl_t       ctl,
  input  logic [AW-1:0]             nb_base,
  input  logic [SW-1:0]             nb_slot,
  input  logic [AW-1:0]             new_base,
  input  logic [SW-1:0]             new_slot,
  input  logic [AW-1:0]             addr,
  input  logic [lbct_pkg::BsW-1:0]  bs,
  output logic [AW-1:0]             base_o,
  output logic [SW-1:0]             slot_o,
  output logic                      match_o
);

  localparam int CmpW = (AW > lbct_pkg::BsW) ? AW : lbct_pkg::BsW;

  logic [AW-1:0] base_r;
  logic [SW-1:0] slot_r;
  logic [AW-1:0] diff;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      base_r <= new_base;
      slot_r <= new_slot;
    end else if (ctl.shift) begin
      base_r <= nb_base;
      slot_r <= nb_slot;
    end
  end

  // The address lies in this block when base <= addr < base + size.
  assign diff    = addr - base_r;
  assign match_o = (base_r <= addr) && (CmpW'(diff) < CmpW'(bs));
  assign base_o  = base_r;
  assign slot_o  = slot_r;

endmodule

// ===== design/lbct_divider.sv =====
// Restoring remainder unit: address modulo block size, one bit per cycle.
// Depends on lbct_pkg.
module lbct_divider #(
  parameter int AW = lbct_pkg::AddressBitsDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [AW-1:0]             dividend,
  input  logic [lbct_pkg::BsW-1:0]  divisor,
  output logic                      done,
  output logic [lbct_pkg::BsW-1:0]  rem
);

  localparam int CntW = $clog2(AW + 1);

  logic                      busy_r;
  logic [CntW-1:0]           cnt_r;
  logic [AW-1:0]             quo_r;
  logic [lbct_pkg::BsW-1:0]  rem_r;
  logic                      done_r;
  logic [lbct_pkg::BsW:0]    trial;

  assign trial = {rem_r, quo_r[AW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(AW);
        quo_r  <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        quo_r <= {quo_r[AW-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem_r <= lbct_pkg::BsW'(trial - {1'b0, divisor});
        end else begin
          rem_r <= trial[lbct_pkg::BsW-1:0];
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== design/lru_block_cache_tags_top.sv =====
// Top level of the block cache tag store: the recency row of cells, the
// remainder unit and the operation sequencer. Depends on lbct_pkg, lbct_cell, lbct_divider.
//
//  Channel | Direction | Handshake          | Contents
//  in_     | slave     | tvalid/tready      | tdata: operation, address, write_length
//  out_    | master    | tvalid/tready      | tdata: result fields; tlast ends an item
//  cfg_    | write     | cfg_we             | cfg_addr 0 block size, 1 capacity
//
// A lookup or a hit goes through S_FIND and S_RES; S_RES loads its result word
// into the output register. An allocating miss first runs the remainder unit
// in S_DIV, then S_ALLOC loads its word. Unless stalled, a clear gives one
// word per cycle per resident entry. One item is worked on at a time; the next is
// taken as soon as the last word of the current one sits in the output register.
// Reset (rst_n low, synchronous) empties the row and restores both registers.
// A stalled output holds the word and the sequencer waits before the next one.
module lru_block_cache_tags_top #(
  parameter int MAX_ENTRIES  = lbct_pkg::MaxEntriesDefault,
  parameter int ADDRESS_BITS = lbct_pkg::AddressBitsDefault,
  localparam int InW  = ((2 + ADDRESS_BITS + lbct_pkg::LenW + 7) / 8) * 8,
  localparam int OutW = ((44 + ADDRESS_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // operation[1:0], address, write_length, zero fill
  input  logic [InW-1:0]  in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // hit, ok, slot[3:0], inner_offset[15:0], room_left[16:0], evicted,
  // evicted_base, evicted_slot[3:0], zero fill
  output logic [OutW-1:0] out_tdata,
  output logic            out_tlast,
  input  logic            cfg_we,
  input  logic            cfg_addr,
  input  logic [16:0]     cfg_wdata
);

  localparam int AW  = ADDRESS_BITS;
  localparam int N   = MAX_ENTRIES;
  localparam int SW  = (N > 1) ? $clog2(N) : 1;
  localparam int CW  = $clog2(N + 1);
  localparam int BsW = lbct_pkg::BsW;
  localparam int PadW = OutW - (44 + AW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_RES   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [BsW-1:0]           bs_r;
  logic [lbct_pkg::CapW-1:0] cap_r;
  logic [BsW-1:0]           bs_eff;
  logic [CW-1:0]            cap_eff;

  logic [1:0]                  op_r;
  logic [AW-1:0]               addr_r;
  logic [lbct_pkg::LenW-1:0]   len_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               used_r, used_nxt;
  logic [N-1:0]                match_r;

  // Output register.
  logic            ov_r, ov_nxt;
  logic            o_hit_r, o_ok_r, o_ev_r, o_last_r;
  logic [3:0]      o_slot_r, o_evs_r;
  logic [15:0]     o_inner_r;
  logic [16:0]     o_room_r;
  logic [AW-1:0]   o_evb_r;
  logic            o_load;
  logic            o_hit, o_ok, o_ev, o_last;
  logic [3:0]      o_slot, o_evs;
  logic [15:0]     o_inner;
  logic [16:0]     o_room;
  logic [AW-1:0]   o_evb;

  logic out_free;
  logic accept;

  // Row wiring.
  lbct_pkg::cell_ctl_t ctl [N];
  logic [AW-1:0] cbase [N];
  logic [SW-1:0] cslot [N];
  logic [N-1:0]  cmatch;
  logic [AW-1:0] new_base;
  logic [SW-1:0] new_slot;

  // Selected entry.
  logic          any_hit;
  logic [SW-1:0] hidx;
  logic [AW-1:0] hbase;
  logic [SW-1:0] hslot;
  logic [AW-1:0] hdiff;
  logic [16:0]   hroom;
  logic          hok;

  logic            div_start, div_done;
  logic [BsW-1:0]  rem;
  logic [16:0]     aroom;
  logic            full;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free = !ov_r || out_tready;

  // Effective register values: zero acts as one, large values saturate.
  always_comb begin
    if (bs_r == '0) bs_eff = BsW'(1);
    else if (bs_r > BsW'(65536)) bs_eff = BsW'(65536);
    else bs_eff = bs_r;
    if (cap_r == '0) cap_eff = CW'(1);
    else if (32'(cap_r) > 32'(N)) cap_eff = CW'(N);
    else cap_eff = CW'(cap_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r  <= lbct_pkg::BsReset;
      cap_r <= lbct_pkg::CapReset;
    end else if (cfg_we) begin
      if (cfg_addr == lbct_pkg::CFG_BLOCK_SIZE) bs_r <= cfg_wdata;
      else cap_r <= cfg_wdata[lbct_pkg::CapW-1:0];
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_row
      logic [AW-1:0] nb_b;
      logic [SW-1:0] nb_s;
      if (g == N - 1) begin : g_end
        assign nb_b = cbase[g];
        assign nb_s = cslot[g];
      end else begin : g_mid
        assign nb_b = cbase[g+1];
        assign nb_s = cslot[g+1];
      end
      lbct_cell #(.AW(AW), .SW(SW)) u_cell (
        .clk     (clk),
        .ctl     (ctl[g]),
        .nb_base (nb_b),
        .nb_slot (nb_s),
        .new_base(new_base),
        .new_slot(new_slot),
        .addr    (addr_r),
        .bs      (bs_eff),
        .base_o  (cbase[g]),
        .slot_o  (cslot[g]),
        .match_o (cmatch[g])
      );
    end
  endgenerate

  lbct_divider #(.AW(AW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(addr_r),
    .divisor (bs_eff),
    .done    (div_done),
    .rem     (rem)
  );

  // Newest match wins: the highest index among resident entries.
  always_comb begin
    any_hit = |match_r;
    hidx    = '0;
    for (int i = 0; i < N; i++) begin
      if (match_r[i]) hidx = SW'(i);
    end
  end

  assign hbase = cbase[hidx];
  assign hslot = cslot[hidx];
  assign hdiff = addr_r - hbase;
  assign hroom = 17'(bs_eff - BsW'(hdiff[15:0]));
  assign hok   = !((op_r == lbct_pkg::OP_WRITE) && (len_r > hroom));
  assign aroom = 17'(bs_eff - rem);
  assign full  = (count_r >= cap_eff);

  function automatic logic [3:0] slot4(input logic [SW-1:0] s);
    logic [SW+3:0] w;
    w = {4'd0, s};
    return w[3:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    used_nxt  = used_r;
    div_start = 1'b0;
    new_base  = hbase;
    new_slot  = hslot;
    o_load    = 1'b0;
    o_hit = 1'b0; o_ok = 1'b1; o_slot = '0; o_inner = '0; o_room = '0;
    o_ev = 1'b0; o_evb = '0; o_evs = '0; o_last = 1'b1;
    for (int i = 0; i < N; i++) ctl[i] = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tdata[1:0] == lbct_pkg::OP_CLEAR) state_nxt = S_CLR;
          else state_nxt = S_FIND;
        end
      end
      S_FIND: state_nxt = S_RES;
      S_RES: begin
        if (any_hit) begin
          if (out_free) begin
            o_load  = 1'b1;
            o_hit   = 1'b1;
            o_ok    = hok;
            o_slot  = slot4(hslot);
            o_inner = hdiff[15:0];
            o_room  = hroom;
            // A write that fits moves its entry to the newest place.
            if (op_r == lbct_pkg::OP_WRITE && hok) begin
              for (int i = 0; i < N; i++) begin
                if (CW'(i) + CW'(1) == count_r) ctl[i].load = 1'b1;
                else if (CW'(i) < count_r && SW'(i) >= hidx) ctl[i].shift = 1'b1;
              end
            end
            state_nxt = S_IDLE;
          end
        end else if (op_r == lbct_pkg::OP_LOOKUP) begin
          if (out_free) begin
            o_load    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        new_base = addr_r - AW'(rem);
        new_slot = full ? cslot[0] : used_r[SW-1:0];
        if (out_free) begin
          o_load  = 1'b1;
          o_ok    = !((op_r == lbct_pkg::OP_WRITE) && (len_r > aroom));
          o_slot  = slot4(new_slot);
          o_inner = rem[15:0];
          o_room  = aroom;
          if (full) begin
            // Oldest leaves, the row moves down, the newcomer takes the top.
            o_ev  = 1'b1;
            o_evb = cbase[0];
            o_evs = slot4(cslot[0]);
            for (int i = 0; i < N; i++) begin
              if (CW'(i) + CW'(1) == count_r) ctl[i].load = 1'b1;
              else if (CW'(i) < count_r) ctl[i].shift = 1'b1;
            end
          end else begin
            for (int i = 0; i < N; i++) begin
              if (CW'(i) == count_r) ctl[i].load = 1'b1;
            end
            count_nxt = count_r + 1'b1;
            used_nxt  = used_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        if (out_free) begin
          o_load = 1'b1;
          if (count_r == '0) begin
            used_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            o_ev   = 1'b1;
            o_evb  = cbase[0];
            o_evs  = slot4(cslot[0]);
            o_last = (count_r == CW'(1));
            for (int i = 0; i < N; i++) ctl[i].shift = 1'b1;
            count_nxt = count_r - 1'b1;
            if (count_r == CW'(1)) begin
              used_nxt  = '0;
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_tready) ov_nxt = 1'b0;
    if (o_load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      used_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_tdata[1:0];
      addr_r <= in_tdata[AW+1:2];
      len_r  <= in_tdata[AW+18:AW+2];
    end
    if (state_r == S_FIND) begin
      for (int i = 0; i < N; i++) match_r[i] <= cmatch[i] && (CW'(i) < count_r);
    end
    if (o_load) begin
      o_hit_r   <= o_hit;
      o_ok_r    <= o_ok;
      o_slot_r  <= o_slot;
      o_inner_r <= o_inner;
      o_room_r  <= o_room;
      o_ev_r    <= o_ev;
      o_evb_r   <= o_evb;
      o_evs_r   <= o_evs;
      o_last_r  <= o_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {{PadW{1'b0}}, o_evs_r, o_evb_r, o_ev_r, o_room_r, o_inner_r,
                       o_slot_r, o_ok_r, o_hit_r};

endmodule
